// ===== hdl/uad_pkg.sv =====
// ----------------------------------------------------------------------------
// uad_pkg
// Shared types, constants and character helpers for the unsigned to ASCII
// digit converter.
// ----------------------------------------------------------------------------
package uad_pkg;

   localparam int VALUE_W   = 32;
   localparam int CHAR_W    = 8;
   localparam int DIGIT_W   = 4;
   localparam int DIGITS    = 10;
   localparam int NIBBLES   = VALUE_W / DIGIT_W;
   localparam int CNT_W     = 4;
   localparam int BIT_CNT_W = 5;

   localparam logic [CNT_W-1:0]     HEX_START = 4'd9;
   localparam logic [CNT_W-1:0]     HEX_X_POS = 4'd8;
   localparam logic [BIT_CNT_W-1:0] BIT_LAST  = 5'd31;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_X    = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;

   localparam logic KIND_DEC = 1'b0;
   localparam logic KIND_HEX = 1'b1;

   typedef struct packed {
      logic load;
      logic shift;
      logic locate;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic conv_done;
      logic last;
   } status_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] nib);
      logic [CHAR_W-1:0] ch;
      if (nib < 4'd10) begin
         ch = CHAR_ZERO + {4'd0, nib};
      end else begin
         ch = CHAR_A + {4'd0, nib - 4'd10};
      end
      return ch;
   endfunction

endpackage

// ===== hdl/unsigned_to_ascii_digits.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits
// Converts a 32-bit unsigned value to ASCII characters, decimal or 0x hex.
// Hex: first character valid the cycle after accept, 10 words.
// Decimal: a shift/add-3 step per bit, a locate step, then 1 to 10 words;
//   the BCD converter takes one bit per cycle.
// One item at a time; the next is accepted after the last word is taken.
// Synchronous active-high reset returns to idle with req_ready high.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_digits (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [uad_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [uad_pkg::CHAR_W-1:0]    rsp_ascii_char,
   output logic                          rsp_last
);

   uad_pkg::cmd_type    cmd;
   uad_pkg::status_type status;

   uad_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   uad_datapath u_dp (
      .clock          (clock),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== hdl/uad_datapath.sv =====
// ----------------------------------------------------------------------------
// uad_datapath
// Binary to BCD shift/add-3 converter, leading digit search and character
// selection for decimal and hex output.
// ----------------------------------------------------------------------------
module uad_datapath (
   input  logic                                 clock,
   input  logic                                 req_kind,
   input  logic [uad_pkg::VALUE_W-1:0]          req_value,
   input  uad_pkg::cmd_type                     cmd,
   output uad_pkg::status_type                  status,
   output logic [uad_pkg::CHAR_W-1:0]           rsp_ascii_char,
   output logic                                 rsp_last
);

   logic                                    kind_ff, kind_in;
   logic [uad_pkg::NIBBLES-1:0][uad_pkg::DIGIT_W-1:0] bin_ff, bin_in;
   logic [uad_pkg::DIGIT_W-1:0]             bcd_ff [uad_pkg::DIGITS];
   logic [uad_pkg::DIGIT_W-1:0]             bcd_in [uad_pkg::DIGITS];
   logic [uad_pkg::DIGIT_W-1:0]             adj    [uad_pkg::DIGITS];
   logic [uad_pkg::CNT_W-1:0]               cnt_ff, cnt_in;
   logic [uad_pkg::BIT_CNT_W-1:0]           bit_cnt_ff, bit_cnt_in;
   logic [uad_pkg::CNT_W-1:0]               lead;

   // add-3 correction per digit
   always_comb begin
      for (int i = 0; i < uad_pkg::DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   always_comb begin
      lead = '0;
      for (int i = 0; i < uad_pkg::DIGITS; i++) begin
         if (bcd_ff[i] != '0) begin
            lead = i[uad_pkg::CNT_W-1:0];
         end
      end
   end

   always_comb begin
      kind_in    = kind_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      cnt_in     = cnt_ff;
      bit_cnt_in = bit_cnt_ff;
      if (cmd.load) begin
         kind_in    = req_kind;
         bin_in     = req_value;
         cnt_in     = uad_pkg::HEX_START;
         bit_cnt_in = '0;
         for (int i = 0; i < uad_pkg::DIGITS; i++) begin
            bcd_in[i] = '0;
         end
      end else if (cmd.shift) begin
         bin_in     = bin_ff << 1;
         bit_cnt_in = bit_cnt_ff + 1'b1;
         bcd_in[0]  = {adj[0][2:0], bin_ff[uad_pkg::NIBBLES-1][uad_pkg::DIGIT_W-1]};
         for (int i = 1; i < uad_pkg::DIGITS; i++) begin
            bcd_in[i] = {adj[i][2:0], adj[i-1][3]};
         end
      end else if (cmd.locate) begin
         cnt_in = lead;
      end else if (cmd.advance) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      cnt_ff     <= cnt_in;
      bit_cnt_ff <= bit_cnt_in;
   end

   always_comb begin
      if (kind_ff == uad_pkg::KIND_HEX) begin
         if (cnt_ff == uad_pkg::HEX_START) begin
            rsp_ascii_char = uad_pkg::CHAR_ZERO;
         end else if (cnt_ff == uad_pkg::HEX_X_POS) begin
            rsp_ascii_char = uad_pkg::CHAR_X;
         end else begin
            rsp_ascii_char = uad_pkg::hex_char(bin_ff[cnt_ff[2:0]]);
         end
      end else begin
         rsp_ascii_char = uad_pkg::CHAR_ZERO + {4'd0, bcd_ff[cnt_ff]};
      end
   end

   assign rsp_last         = (cnt_ff == '0);
   assign status.last      = rsp_last;
   assign status.conv_done = (bit_cnt_ff == uad_pkg::BIT_LAST);

endmodule

// ===== hdl/uad_controller.sv =====
// ----------------------------------------------------------------------------
// uad_controller
// Sequencer: accepts a word, runs the decimal conversion when needed, then
// hands characters out one word at a time.
// ----------------------------------------------------------------------------
module uad_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  uad_pkg::status_type status,
   output uad_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      IDLE,
      CONVERT,
      LOCATE,
      EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      valid_in = valid_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               ready_in = 1'b0;
               if (req_kind == uad_pkg::KIND_HEX) begin
                  state_in = EMIT;
                  valid_in = 1'b1;
               end else begin
                  state_in = CONVERT;
               end
            end
         end
         CONVERT: begin
            cmd.shift = 1'b1;
            if (status.conv_done) begin
               state_in = LOCATE;
            end
         end
         LOCATE: begin
            cmd.locate = 1'b1;
            state_in   = EMIT;
            valid_in   = 1'b1;
         end
         EMIT: begin
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               if (status.last) begin
                  state_in = IDLE;
                  valid_in = 1'b0;
                  ready_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = IDLE;
            valid_in = 1'b0;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ready_ff && valid_ff))
      else $error("input and output both open");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT) |-> valid_ff)
      else $error("emit state without valid");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_ready && status.last) |=> (ready_ff && !valid_ff))
      else $error("last word did not return to idle");

   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !ready_ff)
      else $error("ready after load");

endmodule
